// ===== hw/rtl/srd_pkg.sv =====
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants for the sparse row dot product block.
// ----------------------------------------------------------------------------
package srd_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int MAX_ROWS_DEF     = 65536;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;

  typedef struct packed {
    logic        valid;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } fma_req_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] result;
  } fma_rsp_t;

endpackage

// ===== hw/rtl/sparse_row_dot_fma.sv =====
// ----------------------------------------------------------------------------
// sparse_row_dot_fma
// Compressed-row sparse matrix times dense vector in binary64.
// ----------------------------------------------------------------------------
// A vector load, a row close and an unused command stream at one per clock
// while no accumulate is in flight. An accumulate holds the command channel
// until its result returns: the column's element is read from the vector
// store into a register, and the next accumulate always depends on the
// accumulator, which comes back from the nine stage multiply-add pipeline.
// A row result sits in an output register, so loads and accumulates go on
// while it waits; only a further row close stalls behind it.
module sparse_row_dot_fma import srd_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF,
  parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [9:0]  index,
  input  logic [63:0] value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] row_sum,
  output logic [15:0] row_number
);

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic          accept, in_range, busy, issue, b_ok;
  logic [AW-1:0] addr;
  logic [63:0]   vstore [VECTOR_DEPTH];
  logic [63:0]   rd_data, a_hold, acc;
  logic [RW-1:0] row_counter;
  fma_req_t      fma_req;
  fma_rsp_t      fma_rsp;

  assign cmd_stall = busy || (command == CMD_CLOSE && res_valid && res_stall);
  assign accept    = cmd_valid && !cmd_stall;
  assign in_range  = 32'(index) < VECTOR_DEPTH;
  assign addr      = AW'(index);

  // vector store
  always_ff @(posedge clk) begin
    if (accept && command == CMD_LOAD && in_range) vstore[addr] <= value;
    rd_data <= vstore[addr];
  end

  always_ff @(posedge clk) begin
    if (accept && command == CMD_ACC) begin
      a_hold <= value;
      b_ok   <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      issue <= 1'b0;
    end else begin
      issue <= accept && command == CMD_ACC;
      if (accept && command == CMD_ACC) busy <= 1'b1;
      else if (fma_rsp.valid) busy <= 1'b0;
    end
  end

  assign fma_req.valid = issue;
  assign fma_req.a     = a_hold;
  assign fma_req.b     = b_ok ? rd_data : '0;
  assign fma_req.c     = acc;

  srd_fma u_fma (
    .clk (clk),
    .rst (rst),
    .req (fma_req),
    .rsp (fma_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      row_counter <= '0;
    end else if (fma_rsp.valid) begin
      acc <= fma_rsp.result;
    end else if (accept && command == CMD_LOAD) begin
      acc         <= '0;
      row_counter <= '0;
    end else if (accept && command == CMD_CLOSE) begin
      acc <= '0;
      if (row_counter == RW'(MAX_ROWS - 1)) row_counter <= '0;
      else row_counter <= row_counter + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && command == CMD_CLOSE) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && command == CMD_CLOSE) begin
      row_sum    <= acc;
      row_number <= 16'(row_counter);
    end
  end

  a_rsp_in_busy: assert property (@(posedge clk) disable iff (rst)
    fma_rsp.valid |-> busy)
    else $error("multiply-add result without an accumulate in flight");

  a_issue_follows: assert property (@(posedge clk) disable iff (rst)
    issue |-> $past(accept && command == CMD_ACC))
    else $error("multiply-add issued without an accumulate transfer");

  a_acc_held: assert property (@(posedge clk) disable iff (rst)
    busy && !fma_rsp.valid |=> $stable(acc))
    else $error("accumulator changed while an accumulate was in flight");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(row_counter) < MAX_ROWS)
    else $error("row counter beyond its wrap point");

endmodule

// ===== hw/rtl/srd_fma.sv =====
// ----------------------------------------------------------------------------
// srd_fma
// Nine stage binary64 fused multiply-add, a*b+c rounded once to nearest-even.
// ----------------------------------------------------------------------------
module srd_fma import srd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fma_req_t req,
  output fma_rsp_t rsp
);

  function automatic logic [6:0] top_bit(input logic [127:0] x);
    logic [6:0] pos;
    pos = '0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) pos = 7'(i);
    end
    return pos;
  endfunction

  // stage 1: unpack, special operands, partial products
  logic               sa, sb, sc, sp;
  logic [10:0]        ea, eb, ec, ea_eff, eb_eff, ec_eff;
  logic [51:0]        fa, fb, fc;
  logic               any_nan, ainf, binf, cinf, azero, bzero, czero;
  logic               spec;
  logic [63:0]        spec_res;
  logic [52:0]        ma, mb, mc;
  logic signed [13:0] pexp_raw, cexp_raw;

  always_comb begin
    sa = req.a[63];
    sb = req.b[63];
    sc = req.c[63];
    sp = sa ^ sb;
    ea = req.a[62:52];
    eb = req.b[62:52];
    ec = req.c[62:52];
    fa = req.a[51:0];
    fb = req.b[51:0];
    fc = req.c[51:0];
    any_nan = (ea == 11'h7FF && fa != '0) || (eb == 11'h7FF && fb != '0) ||
              (ec == 11'h7FF && fc != '0);
    ainf  = ea == 11'h7FF;
    binf  = eb == 11'h7FF;
    cinf  = ec == 11'h7FF;
    azero = ea == '0 && fa == '0;
    bzero = eb == '0 && fb == '0;
    czero = ec == '0 && fc == '0;
    ma = {ea != '0, fa};
    mb = {eb != '0, fb};
    mc = {ec != '0, fc};
    ea_eff = (ea == '0) ? 11'd1 : ea;
    eb_eff = (eb == '0) ? 11'd1 : eb;
    ec_eff = (ec == '0) ? 11'd1 : ec;
    pexp_raw = $signed({3'b000, ea_eff}) + $signed({3'b000, eb_eff}) - 14'sd2150;
    cexp_raw = $signed({3'b000, ec_eff}) - 14'sd1075;
    spec = 1'b1;
    spec_res = '0;
    if (any_nan) begin
      spec_res = QNAN_BITS;
    end else if (ainf || binf) begin
      if (azero || bzero) spec_res = QNAN_BITS;
      else if (cinf && sc != sp) spec_res = QNAN_BITS;
      else spec_res = {sp, INF_BITS[62:0]};
    end else if (cinf) begin
      spec_res = req.c;
    end else if (azero || bzero) begin
      spec_res = czero ? {sp & sc, 63'd0} : req.c;
    end else begin
      spec = 1'b0;
    end
  end

  logic [9:1]         vld;
  logic [9:1]         spc;
  logic [63:0]        sres [1:8];
  logic               s1_sp, s1_sc, s1_cz;
  logic [53:0]        s1_ll;
  logic [52:0]        s1_lh, s1_hl;
  logic [51:0]        s1_hh;
  logic signed [13:0] s1_pe, s1_ce;
  logic [52:0]        s1_mc;

  always_ff @(posedge clk) begin
    s1_sp <= sp;
    s1_sc <= sc;
    s1_cz <= czero;
    s1_ll <= 54'(ma[26:0]) * 54'(mb[26:0]);
    s1_lh <= 53'(ma[26:0]) * 53'(mb[52:27]);
    s1_hl <= 53'(ma[52:27]) * 53'(mb[26:0]);
    s1_hh <= 52'(ma[52:27]) * 52'(mb[52:27]);
    s1_pe <= pexp_raw;
    s1_ce <= cexp_raw;
    s1_mc <= mc;
    sres[1] <= spec_res;
    for (int k = 2; k <= 8; k++) sres[k] <= sres[k-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[8:1], req.valid};
    end
    spc <= {spc[8:1], spec};
  end

  // stage 2: sum partial products
  logic               s2_sp, s2_sc, s2_cz;
  logic [105:0]       s2_p;
  logic signed [13:0] s2_pe, s2_ce;
  logic [52:0]        s2_mc;

  always_ff @(posedge clk) begin
    s2_p <= 106'(s1_ll) + (106'(s1_lh) << 27) + (106'(s1_hl) << 27) +
            (106'(s1_hh) << 54);
    s2_sp <= s1_sp;
    s2_sc <= s1_sc;
    s2_cz <= s1_cz;
    s2_pe <= s1_pe;
    s2_ce <= s1_ce;
    s2_mc <= s1_mc;
  end

  // stage 3: leading one positions
  logic               s3_sp, s3_sc, s3_cz;
  logic [105:0]       s3_p;
  logic [52:0]        s3_mc;
  logic [6:0]         s3_ptop, s3_ctop;
  logic signed [13:0] s3_pe, s3_ce;

  always_ff @(posedge clk) begin
    s3_ptop <= top_bit(128'(s2_p));
    s3_ctop <= top_bit(128'(s2_mc));
    s3_p  <= s2_p;
    s3_mc <= s2_mc;
    s3_sp <= s2_sp;
    s3_sc <= s2_sc;
    s3_cz <= s2_cz;
    s3_pe <= s2_pe;
    s3_ce <= s2_ce;
  end

  // stage 4: normalize both operands to bit 125
  logic [6:0]         shp, shc;
  logic               s4_sp, s4_sc, s4_cz;
  logic [127:0]       s4_x, s4_y;
  logic signed [13:0] s4_pe, s4_ce;

  assign shp = 7'd125 - s3_ptop;
  assign shc = 7'd125 - s3_ctop;

  always_ff @(posedge clk) begin
    s4_x  <= 128'(s3_p) << shp;
    s4_y  <= s3_cz ? '0 : (128'(s3_mc) << shc);
    s4_pe <= s3_pe - $signed({7'd0, shp});
    s4_ce <= s3_ce - $signed({7'd0, shc});
    s4_sp <= s3_sp;
    s4_sc <= s3_sc;
    s4_cz <= s3_cz;
  end

  // stage 5: swap to the larger exponent and align with sticky
  logic               swap, far_a, st_a;
  logic [127:0]       xb, ys, yal;
  logic signed [13:0] eb_a, es_a, d_a;
  logic               sxb, sys;

  always_comb begin
    swap  = !s4_cz && (s4_ce > s4_pe);
    xb    = swap ? s4_y : s4_x;
    ys    = swap ? s4_x : s4_y;
    eb_a  = swap ? s4_ce : s4_pe;
    es_a  = swap ? s4_pe : s4_ce;
    sxb   = swap ? s4_sc : s4_sp;
    sys   = swap ? s4_sp : s4_sc;
    d_a   = eb_a - es_a;
    far_a = d_a >= 14'sd128;
    if (far_a) begin
      yal  = '0;
      st_a = ys != '0;
    end else begin
      yal  = ys >> d_a[6:0];
      st_a = (ys & ~({128{1'b1}} << d_a[6:0])) != '0;
    end
    yal[0] = yal[0] | st_a;
  end

  logic               s5_sx, s5_sy;
  logic [127:0]       s5_x, s5_y;
  logic signed [13:0] s5_re;

  always_ff @(posedge clk) begin
    s5_x  <= xb;
    s5_y  <= yal;
    s5_sx <= sxb;
    s5_sy <= sys;
    s5_re <= eb_a;
  end

  // stage 6: add or subtract magnitudes
  logic [128:0] diff_xy;
  logic [127:0] diff_yx, r_a;
  logic         rs_a, zero_a;

  always_comb begin
    diff_xy = {1'b0, s5_x} - {1'b0, s5_y};
    diff_yx = s5_y - s5_x;
    zero_a  = 1'b0;
    if (s5_sx == s5_sy) begin
      r_a  = s5_x + s5_y;
      rs_a = s5_sx;
    end else if (diff_xy[128]) begin
      r_a  = diff_yx;
      rs_a = s5_sy;
    end else begin
      r_a    = diff_xy[127:0];
      rs_a   = s5_sx;
      zero_a = s5_x == s5_y;
    end
  end

  logic               s6_rs, s6_zero;
  logic [127:0]       s6_r;
  logic signed [13:0] s6_re;

  always_ff @(posedge clk) begin
    s6_r    <= r_a;
    s6_rs   <= rs_a;
    s6_zero <= zero_a;
    s6_re   <= s5_re;
  end

  // stage 7: rounding position, clamped for subnormals
  logic signed [13:0] s_top, s_sub;
  logic               s7_rs, s7_zero;
  logic [127:0]       s7_r;
  logic signed [13:0] s7_re, s7_s;

  assign s_top = $signed({7'd0, top_bit(s6_r)}) - 14'sd52;
  assign s_sub = -14'sd1074 - s6_re;

  always_ff @(posedge clk) begin
    s7_s    <= (s_top > s_sub) ? s_top : s_sub;
    s7_r    <= s6_r;
    s7_rs   <= s6_rs;
    s7_zero <= s6_zero;
    s7_re   <= s6_re;
  end

  // stage 8: shift to the mantissa and find the round-up
  logic signed [13:0] neg_s, sm1;
  logic [127:0]       sh_r;
  logic [52:0]        m_a;
  logic               guard, sticky, rnd_a;

  always_comb begin
    neg_s  = -s7_s;
    sm1    = s7_s - 14'sd1;
    guard  = 1'b0;
    sticky = 1'b0;
    if (s7_s <= 14'sd0) begin
      sh_r = s7_r << neg_s[6:0];
    end else if (s7_s >= 14'sd128) begin
      sh_r = '0;
    end else begin
      sh_r = s7_r >> s7_s[6:0];
    end
    m_a = sh_r[52:0];
    if (s7_s > 14'sd0 && s7_s <= 14'sd128) begin
      guard  = s7_r[sm1[6:0]];
      sticky = (s7_r & ~({128{1'b1}} << sm1[6:0])) != '0;
    end
    rnd_a = guard && (sticky || m_a[0]);
  end

  logic               s8_rs, s8_zero, s8_rnd;
  logic [52:0]        s8_m;
  logic signed [13:0] s8_field;

  always_ff @(posedge clk) begin
    s8_m     <= m_a;
    s8_rnd   <= rnd_a;
    s8_field <= s7_re + s7_s + 14'sd1074;
    s8_rs    <= s7_rs;
    s8_zero  <= s7_zero;
  end

  // stage 9: round and pack
  logic [53:0] mr;
  logic [63:0] bits, packed_res;

  always_comb begin
    mr = 54'(s8_m) + 54'(s8_rnd);
    if (s8_field >= 14'sd2047) begin
      bits = INF_BITS;
    end else begin
      bits = (64'(s8_field[10:0]) << 52) + 64'(mr);
      if (bits >= INF_BITS) bits = INF_BITS;
    end
    if (spc[8]) packed_res = sres[8];
    else if (s8_zero) packed_res = '0;
    else packed_res = {s8_rs, bits[62:0]};
  end

  logic [63:0] result;

  always_ff @(posedge clk) begin
    result <= packed_res;
  end

  assign rsp.valid  = vld[9];
  assign rsp.result = result;

  logic unused_spc;
  assign unused_spc = spc[9];

endmodule
